// File: rtl/gsdfs_pkg.sv
// Shared constants, codes and item types for the graph store and depth-first walker.
package gsdfs_pkg;

    // Graph sizing
    localparam int MAX_NODES   = 64;
    localparam int MAX_EDGES   = 256;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int ENTRY_COUNT = 2 * MAX_EDGES;
    localparam int ENTRY_W     = $clog2(ENTRY_COUNT);
    localparam int LINK_W      = $clog2(ENTRY_COUNT + 1);
    localparam int MAT_DEPTH   = MAX_NODES * MAX_NODES;
    localparam int MAT_AW      = $clog2(MAT_DEPTH);
    localparam int DEPTH_W     = $clog2(MAX_NODES + 1);
    localparam int WEIGHT_W    = 32;

    // End-of-list marker in link fields
    localparam logic [LINK_W-1:0] NO_ENTRY = LINK_W'(ENTRY_COUNT);

    typedef logic [NODE_W-1:0]          t_node;
    typedef logic signed [WEIGHT_W-1:0] t_weight;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_START = 2'd2,
        FUNC_STEP  = 2'd3
    } t_func;

    // Result kind codes
    typedef enum logic [2:0] {
        KIND_ADDED   = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_WEIGHT  = 3'd2,
        KIND_VISIT   = 3'd3,
        KIND_EXAMINE = 3'd4,
        KIND_DONE    = 3'd5
    } t_kind;

    typedef struct packed {
        t_func   func;
        t_node   node_a;
        t_node   node_b;
        t_weight edge_weight_in;
    } t_in_item;

    typedef struct packed {
        t_kind   kind;
        t_node   from_node;
        t_node   to_node;
        t_weight weight_out;
    } t_out_item;

endpackage

// File: rtl/graph_store_dfs_walker_top.sv
// Graph store with weight matrix, adjacency lists and a stack-based depth-first walker.
//
//  Channel   | Direction | Transfer condition      | Payload
//  ----------+-----------+-------------------------+---------------------------
//  command   | in        | start && !busy          | i_item   (gsdfs_pkg::t_in_item)
//  result    | out       | o_strobe, one cycle     | o_result (gsdfs_pkg::t_out_item)
//
// An add edge passes through S_ADD0 to S_ADD3, a query through S_QRY, and a start clears
// the visited marks in S_VCLR, then pushes in S_PUSH; a rejected add and a done step are
// answered from S_IDLE. A step reads the stack top in S_STEP1 for a visit or a pop, adding
// S_STEP2 and S_PUSH for an examined edge whether or not it pushes its child. The cost is
// set by the chain of registered memory reads (stack top, adjacency entry, visited mark and
// list head) and by the single write port of the link memory, which takes up to four writes
// per added edge. After reset a clearing pass zeroes the weight matrix, one cell a cycle,
// with busy high. The receiver cannot stall; busy holds off commands.
module graph_store_dfs_walker_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  gsdfs_pkg::t_in_item   i_item,
    output logic                  busy,
    output logic                  o_strobe,
    output gsdfs_pkg::t_out_item  o_result
);

    localparam int NW = gsdfs_pkg::NODE_W;
    localparam int EW = gsdfs_pkg::ENTRY_W;
    localparam int LW = gsdfs_pkg::LINK_W;
    localparam int AW = gsdfs_pkg::MAT_AW;
    localparam int DW = gsdfs_pkg::DEPTH_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD0, S_ADD1, S_ADD2, S_ADD3,
        S_QRY, S_VCLR, S_STEP1, S_STEP2, S_PUSH
    } t_state;

    typedef struct packed {
        gsdfs_pkg::t_node   target;
        gsdfs_pkg::t_weight weight;
    } t_adj;

    typedef struct packed {
        gsdfs_pkg::t_node  node;
        logic [LW-1:0]     cursor;
    } t_stk;

    // Memories
    gsdfs_pkg::t_weight mem_mat  [gsdfs_pkg::MAT_DEPTH];
    t_adj               mem_adj  [gsdfs_pkg::ENTRY_COUNT];
    logic [LW-1:0]      mem_nxt  [gsdfs_pkg::ENTRY_COUNT];
    logic [EW-1:0]      mem_head [gsdfs_pkg::MAX_NODES];
    logic [EW-1:0]      mem_tail [gsdfs_pkg::MAX_NODES];
    t_stk               mem_stk  [gsdfs_pkg::MAX_NODES];
    logic               mem_vis  [gsdfs_pkg::MAX_NODES];

    // Registered read data
    gsdfs_pkg::t_weight r_mat_rd;
    t_adj               r_adj_rd;
    logic [LW-1:0]      r_nxt_rd;
    logic [EW-1:0]      r_head_rd;
    logic [EW-1:0]      r_tail_rd;
    t_stk               r_stk_rd;
    logic               r_vis_rd;

    // Memory port controls
    logic               mat_we, mat_re;
    logic [AW-1:0]      mat_wa, mat_ra;
    gsdfs_pkg::t_weight mat_wd;
    logic               adj_we, adj_re;
    logic [EW-1:0]      adj_wa, adj_ra;
    t_adj               adj_wd;
    logic               nxt_we;
    logic [EW-1:0]      nxt_wa;
    logic [LW-1:0]      nxt_wd;
    logic               head_we, head_re;
    logic [NW-1:0]      head_wa, head_ra;
    logic [EW-1:0]      head_wd;
    logic               tail_we, tail_re;
    logic [NW-1:0]      tail_wa, tail_ra;
    logic [EW-1:0]      tail_wd;
    logic               stk_we, stk_re;
    logic [NW-1:0]      stk_wa, stk_ra;
    t_stk               stk_wd;
    logic               vis_we, vis_re;
    logic [NW-1:0]      vis_wa, vis_ra;
    logic               vis_wd;

    // Control and payload registers
    t_state                 r_state, n_state;
    gsdfs_pkg::t_in_item    r_item, n_item;
    logic [LW-1:0]          r_used, n_used;
    logic [gsdfs_pkg::MAX_NODES-1:0] r_head_v, n_head_v;
    logic [DW-1:0]          r_depth, n_depth;
    logic                   r_pending, n_pending;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic                   r_fwd, n_fwd;
    gsdfs_pkg::t_node       r_push_node, n_push_node;
    logic                   r_push_start, n_push_start;
    logic                   r_strobe, n_strobe;
    gsdfs_pkg::t_out_item   r_out, n_out;

    // Helpers
    logic [EW-1:0]      slot0, slot1, tail_b;
    logic               in_accept;
    gsdfs_pkg::t_node   child;

    assign in_accept = start && (r_state == S_IDLE);
    assign slot0     = r_used[EW-1:0];
    assign slot1     = EW'(r_used + LW'(1));
    assign tail_b    = r_fwd ? slot0 : r_tail_rd;
    assign child     = r_adj_rd.target;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // Sequencer: next state, memory accesses and results
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_used       = r_used;
        n_head_v     = r_head_v;
        n_depth      = r_depth;
        n_pending    = r_pending;
        n_clr_addr   = r_clr_addr;
        n_fwd        = r_fwd;
        n_push_node  = r_push_node;
        n_push_start = r_push_start;
        n_strobe     = 1'b0;
        n_out        = r_out;

        mat_we = 1'b0; mat_wa = '0; mat_wd = '0; mat_re = 1'b0; mat_ra = '0;
        adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_re = 1'b0; adj_ra = '0;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
        head_we = 1'b0; head_wa = '0; head_wd = '0; head_re = 1'b0; head_ra = '0;
        tail_we = 1'b0; tail_wa = '0; tail_wd = '0; tail_re = 1'b0; tail_ra = '0;
        stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_re = 1'b0; stk_ra = '0;
        vis_we = 1'b0; vis_wa = '0; vis_wd = 1'b0; vis_re = 1'b0; vis_ra = '0;

        unique case (r_state)
            // Zero the weight matrix after reset
            S_CLEAR: begin
                mat_we     = 1'b1;
                mat_wa     = r_clr_addr;
                n_clr_addr = AW'(r_clr_addr + AW'(1));
                if (r_clr_addr == AW'(gsdfs_pkg::MAT_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Take a command and dispatch
            S_IDLE: begin
                if (in_accept) begin
                    n_item = i_item;
                    unique case (i_item.func)
                        gsdfs_pkg::FUNC_ADD: begin
                            if (int'(i_item.node_a) >= gsdfs_pkg::MAX_NODES ||
                                int'(i_item.node_b) >= gsdfs_pkg::MAX_NODES ||
                                (r_used + LW'(2)) > LW'(gsdfs_pkg::ENTRY_COUNT)) begin
                                n_strobe         = 1'b1;
                                n_out.kind       = gsdfs_pkg::KIND_FULL;
                                n_out.from_node  = i_item.node_a;
                                n_out.to_node    = i_item.node_b;
                                n_out.weight_out = i_item.edge_weight_in;
                            end else begin
                                n_state = S_ADD0;
                            end
                        end
                        gsdfs_pkg::FUNC_QUERY: begin
                            mat_re  = 1'b1;
                            mat_ra  = AW'(AW'(i_item.node_a) * AW'(gsdfs_pkg::MAX_NODES)
                                      + AW'(i_item.node_b));
                            n_state = S_QRY;
                        end
                        gsdfs_pkg::FUNC_START: begin
                            n_depth   = '0;
                            n_pending = 1'b0;
                            if (int'(i_item.node_a) < gsdfs_pkg::MAX_NODES) begin
                                n_push_node  = i_item.node_a;
                                n_push_start = 1'b1;
                                n_state      = S_VCLR;
                            end
                        end
                        gsdfs_pkg::FUNC_STEP: begin
                            if (!r_pending && r_depth == '0) begin
                                n_strobe = 1'b1;
                                n_out    = '{kind: gsdfs_pkg::KIND_DONE, default: '0};
                            end else begin
                                stk_re  = 1'b1;
                                stk_ra  = NW'(r_depth - DW'(1));
                                n_state = S_STEP1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Add edge: first matrix cell, entry for node_a, read tail of node_a
            S_ADD0: begin
                mat_we  = 1'b1;
                mat_wa  = AW'(AW'(r_item.node_a) * AW'(gsdfs_pkg::MAX_NODES)
                          + AW'(r_item.node_b));
                mat_wd  = r_item.edge_weight_in;
                adj_we  = 1'b1;
                adj_wa  = slot0;
                adj_wd  = '{target: r_item.node_b, weight: r_item.edge_weight_in};
                nxt_we  = 1'b1;
                nxt_wa  = slot0;
                nxt_wd  = gsdfs_pkg::NO_ENTRY;
                tail_re = 1'b1;
                tail_ra = r_item.node_a;
                n_state = S_ADD1;
            end

            // Link entry into node_a's list, second matrix cell, read tail of node_b
            S_ADD1: begin
                mat_we = 1'b1;
                mat_wa = AW'(AW'(r_item.node_b) * AW'(gsdfs_pkg::MAX_NODES)
                         + AW'(r_item.node_a));
                mat_wd = r_item.edge_weight_in;
                if (r_head_v[r_item.node_a]) begin
                    nxt_we = 1'b1;
                    nxt_wa = r_tail_rd;
                    nxt_wd = LW'(slot0);
                end else begin
                    head_we                 = 1'b1;
                    head_wa                 = r_item.node_a;
                    head_wd                 = slot0;
                    n_head_v[r_item.node_a] = 1'b1;
                end
                tail_we = 1'b1;
                tail_wa = r_item.node_a;
                tail_wd = slot0;
                // Tail read returns the old value; forward the new tail on a self loop
                tail_re = 1'b1;
                tail_ra = r_item.node_b;
                n_fwd   = (r_item.node_a == r_item.node_b);
                adj_we  = 1'b1;
                adj_wa  = slot1;
                adj_wd  = '{target: r_item.node_a, weight: r_item.edge_weight_in};
                n_state = S_ADD2;
            end

            // Terminate the second entry
            S_ADD2: begin
                nxt_we  = 1'b1;
                nxt_wa  = slot1;
                nxt_wd  = gsdfs_pkg::NO_ENTRY;
                n_state = S_ADD3;
            end

            // Link entry into node_b's list and report
            S_ADD3: begin
                if (r_head_v[r_item.node_b]) begin
                    nxt_we = 1'b1;
                    nxt_wa = tail_b;
                    nxt_wd = LW'(slot1);
                end else begin
                    head_we                 = 1'b1;
                    head_wa                 = r_item.node_b;
                    head_wd                 = slot1;
                    n_head_v[r_item.node_b] = 1'b1;
                end
                tail_we          = 1'b1;
                tail_wa          = r_item.node_b;
                tail_wd          = slot1;
                n_used           = LW'(r_used + LW'(2));
                n_strobe         = 1'b1;
                n_out.kind       = gsdfs_pkg::KIND_ADDED;
                n_out.from_node  = r_item.node_a;
                n_out.to_node    = r_item.node_b;
                n_out.weight_out = r_item.edge_weight_in;
                n_state          = S_IDLE;
            end

            // Query reply
            S_QRY: begin
                n_strobe        = 1'b1;
                n_out.kind      = gsdfs_pkg::KIND_WEIGHT;
                n_out.from_node = r_item.node_a;
                n_out.to_node   = r_item.node_b;
                if (int'(r_item.node_a) < gsdfs_pkg::MAX_NODES &&
                    int'(r_item.node_b) < gsdfs_pkg::MAX_NODES) begin
                    n_out.weight_out = r_mat_rd;
                end else begin
                    n_out.weight_out = '0;
                end
                n_state = S_IDLE;
            end

            // Start: clear the visited marks one per cycle, then fetch the start node's head
            S_VCLR: begin
                vis_we = 1'b1;
                vis_wa = r_clr_addr[NW-1:0];
                vis_wd = 1'b0;
                if (r_clr_addr[NW-1:0] == NW'(gsdfs_pkg::MAX_NODES - 1)) begin
                    head_re    = 1'b1;
                    head_ra    = r_push_node;
                    n_clr_addr = '0;
                    n_state    = S_PUSH;
                end else begin
                    n_clr_addr = AW'(r_clr_addr + AW'(1));
                end
            end

            // Step: stack top is read; visit, pop or fetch next entry
            S_STEP1: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    n_strobe  = 1'b1;
                    n_out     = '{kind: gsdfs_pkg::KIND_VISIT, from_node: r_stk_rd.node,
                                  default: '0};
                    n_state   = S_IDLE;
                end else if (r_stk_rd.cursor >= LW'(gsdfs_pkg::ENTRY_COUNT)) begin
                    n_depth = DW'(r_depth - DW'(1));
                    n_state = S_IDLE;
                end else begin
                    adj_re  = 1'b1;
                    adj_ra  = r_stk_rd.cursor[EW-1:0];
                    n_state = S_STEP2;
                end
            end

            // Step: report edge, advance cursor, read the child's mark and list head
            S_STEP2: begin
                stk_we           = 1'b1;
                stk_wa           = NW'(r_depth - DW'(1));
                stk_wd           = '{node: r_stk_rd.node, cursor: r_nxt_rd};
                n_strobe         = 1'b1;
                n_out.kind       = gsdfs_pkg::KIND_EXAMINE;
                n_out.from_node  = r_stk_rd.node;
                n_out.to_node    = child;
                n_out.weight_out = r_adj_rd.weight;
                vis_re           = 1'b1;
                vis_ra           = child;
                head_re          = 1'b1;
                head_ra          = child;
                n_push_node      = child;
                n_push_start     = 1'b0;
                n_state          = S_PUSH;
            end

            // Push a node with its list head as cursor; a child only when unvisited
            S_PUSH: begin
                if (int'(r_depth) < gsdfs_pkg::MAX_NODES && (r_push_start || !r_vis_rd)) begin
                    stk_we        = 1'b1;
                    stk_wa        = r_depth[NW-1:0];
                    stk_wd.node   = r_push_node;
                    stk_wd.cursor = r_head_v[r_push_node] ? LW'(r_head_rd)
                                                          : gsdfs_pkg::NO_ENTRY;
                    vis_we        = 1'b1;
                    vis_wa        = r_push_node;
                    vis_wd        = 1'b1;
                    n_depth       = DW'(r_depth + DW'(1));
                    n_pending     = 1'b1;
                end
                n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_used     <= '0;
            r_head_v   <= '0;
            r_depth    <= '0;
            r_pending  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_used     <= n_used;
            r_head_v   <= n_head_v;
            r_depth    <= n_depth;
            r_pending  <= n_pending;
            r_strobe   <= n_strobe;
        end
        r_item       <= n_item;
        r_fwd        <= n_fwd;
        r_push_node  <= n_push_node;
        r_push_start <= n_push_start;
        r_out        <= n_out;
    end

    // Weight matrix
    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            mem_mat[mat_wa] <= mat_wd;
        end
        if (mat_re) begin
            r_mat_rd <= mem_mat[mat_ra];
        end
    end

    // Adjacency target and weight
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            mem_adj[adj_wa] <= adj_wd;
        end
        if (adj_re) begin
            r_adj_rd <= mem_adj[adj_ra];
        end
    end

    // Adjacency links, read alongside the entry
    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            mem_nxt[nxt_wa] <= nxt_wd;
        end
        if (adj_re) begin
            r_nxt_rd <= mem_nxt[adj_ra];
        end
    end

    // List heads
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            mem_head[head_wa] <= head_wd;
        end
        if (head_re) begin
            r_head_rd <= mem_head[head_ra];
        end
    end

    // List tails
    always_ff @(posedge i_clk) begin
        if (tail_we) begin
            mem_tail[tail_wa] <= tail_wd;
        end
        if (tail_re) begin
            r_tail_rd <= mem_tail[tail_ra];
        end
    end

    // Walk stack
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            mem_stk[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_rd <= mem_stk[stk_ra];
        end
    end

    // Visited marks
    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            mem_vis[vis_wa] <= vis_wd;
        end
        if (vis_re) begin
            r_vis_rd <= mem_vis[vis_ra];
        end
    end

endmodule

// File: sim/graph_store_dfs_walker_top_tb.sv
// Self-checking testbench for the graph store and depth-first walker.
module graph_store_dfs_walker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT = 600000;
    localparam int QUIET_FIRST = 700;
    localparam int QUIET_LAST  = 1000;
    localparam int SETTLE_CYCLES = 10;

    localparam int MAX_NODES   = gsdfs_pkg::MAX_NODES;
    localparam int MAT_DEPTH   = gsdfs_pkg::MAT_DEPTH;
    localparam int ENTRY_COUNT = gsdfs_pkg::ENTRY_COUNT;
    localparam int ENTRY_W     = gsdfs_pkg::ENTRY_W;
    localparam int LINK_W      = gsdfs_pkg::LINK_W;
    localparam logic [LINK_W-1:0] NO_ENTRY = gsdfs_pkg::NO_ENTRY;

    // One queued command; hold_off makes the sender drain all results first
    typedef struct packed {
        logic                hold_off;
        gsdfs_pkg::t_in_item item;
    } t_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    gsdfs_pkg::t_in_item  i_item = '0;
    logic                 busy;
    logic                 o_strobe;
    gsdfs_pkg::t_out_item o_result;

    t_cmd                 cmd_queue[$];
    gsdfs_pkg::t_out_item expected_results[$];

    logic accepted = 1'b0;
    int   items_sent = 0;
    int   items_queued = 0;
    int   cycle_count = 0;
    int   fail_count = 0;

    // Coverage tallies for the closing summary
    int n_added = 0, n_full = 0, n_queries = 0, n_starts = 0;
    int n_visits = 0, n_examined = 0, n_pops = 0, n_done = 0;

    // Shadow copy of the graph store and the walker
    gsdfs_pkg::t_weight mat_w       [MAT_DEPTH];
    gsdfs_pkg::t_node   link_target [ENTRY_COUNT];
    gsdfs_pkg::t_weight link_weight [ENTRY_COUNT];
    logic [LINK_W-1:0]  link_next   [ENTRY_COUNT];
    logic [LINK_W-1:0]  head_of     [MAX_NODES];
    logic [ENTRY_W-1:0] tail_of     [MAX_NODES];
    int                 used_entries;
    logic               seen        [MAX_NODES];
    gsdfs_pkg::t_node   walk_node   [MAX_NODES];
    logic [LINK_W-1:0]  walk_cursor [MAX_NODES];
    int                 walk_depth;
    logic               visit_due;

    graph_store_dfs_walker_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Append one result to the expected queue
    function automatic void add_expected(gsdfs_pkg::t_out_item r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Append one entry to a node's adjacency list
    function automatic void add_link(gsdfs_pkg::t_node owner, gsdfs_pkg::t_node target,
                                     gsdfs_pkg::t_weight w);
        int slot;
        slot = used_entries;
        link_target[slot] = target;
        link_weight[slot] = w;
        link_next[slot] = NO_ENTRY;
        if (head_of[owner] == NO_ENTRY)
            head_of[owner] = LINK_W'(slot);
        else
            link_next[tail_of[owner]] = LINK_W'(slot);
        tail_of[owner] = ENTRY_W'(slot);
        used_entries++;
    endfunction

    function automatic void push_walk(gsdfs_pkg::t_node n);
        if (walk_depth >= MAX_NODES)
            return;
        walk_node[walk_depth] = n;
        walk_cursor[walk_depth] = head_of[n];
        walk_depth++;
        seen[n] = 1'b1;
        visit_due = 1'b1;
    endfunction

    // Advance the shadow graph by one command, queue the result, if any, that it causes
    function automatic void predict_item(gsdfs_pkg::t_in_item it);
        gsdfs_pkg::t_out_item r;
        int top;
        logic [LINK_W-1:0] cur;
        r = '0;
        case (it.func)
            gsdfs_pkg::FUNC_ADD: begin
                r.from_node = it.node_a;
                r.to_node = it.node_b;
                r.weight_out = it.edge_weight_in;
                if (used_entries + 2 > ENTRY_COUNT) begin
                    r.kind = gsdfs_pkg::KIND_FULL;
                    n_full++;
                end else begin
                    mat_w[{it.node_a, it.node_b}] = it.edge_weight_in;
                    mat_w[{it.node_b, it.node_a}] = it.edge_weight_in;
                    add_link(it.node_a, it.node_b, it.edge_weight_in);
                    add_link(it.node_b, it.node_a, it.edge_weight_in);
                    r.kind = gsdfs_pkg::KIND_ADDED;
                    n_added++;
                end
                add_expected(r);
            end
            gsdfs_pkg::FUNC_QUERY: begin
                r.kind = gsdfs_pkg::KIND_WEIGHT;
                r.from_node = it.node_a;
                r.to_node = it.node_b;
                r.weight_out = mat_w[{it.node_a, it.node_b}];
                n_queries++;
                add_expected(r);
            end
            gsdfs_pkg::FUNC_START: begin
                for (int i = 0; i < MAX_NODES; i++)
                    seen[i] = 1'b0;
                walk_depth = 0;
                visit_due = 1'b0;
                push_walk(it.node_a);
                n_starts++;
            end
            default: begin
                if (visit_due) begin
                    visit_due = 1'b0;
                    r.kind = gsdfs_pkg::KIND_VISIT;
                    r.from_node = walk_node[walk_depth - 1];
                    n_visits++;
                    add_expected(r);
                end else if (walk_depth == 0) begin
                    r.kind = gsdfs_pkg::KIND_DONE;
                    n_done++;
                    add_expected(r);
                end else begin
                    top = walk_depth - 1;
                    cur = walk_cursor[top];
                    if (cur >= ENTRY_COUNT) begin
                        // list exhausted: pop without a result
                        walk_depth = top;
                        n_pops++;
                    end else begin
                        r.kind = gsdfs_pkg::KIND_EXAMINE;
                        r.from_node = walk_node[top];
                        r.to_node = link_target[cur];
                        r.weight_out = link_weight[cur];
                        walk_cursor[top] = link_next[cur];
                        n_examined++;
                        add_expected(r);
                        if (!seen[r.to_node])
                            push_walk(r.to_node);
                    end
                end
            end
        endcase
    endfunction

    function automatic void queue_cmd(gsdfs_pkg::t_func f, gsdfs_pkg::t_node a,
                                      gsdfs_pkg::t_node b, gsdfs_pkg::t_weight w,
                                      logic hold = 1'b0);
        t_cmd c;
        c.hold_off = hold;
        c.item.func = f;
        c.item.node_a = a;
        c.item.node_b = b;
        c.item.edge_weight_in = w;
        cmd_queue.insert(cmd_queue.size(), c);
        items_queued++;
    endfunction

    // Mostly inside the window, sometimes anywhere
    function automatic gsdfs_pkg::t_node pick_node(int lo, int hi);
        if ($urandom_range(0, 7) == 0)
            return gsdfs_pkg::t_node'($urandom_range(0, MAX_NODES - 1));
        return gsdfs_pkg::t_node'($urandom_range(lo, hi));
    endfunction

    function automatic gsdfs_pkg::t_weight pick_weight();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            default: return gsdfs_pkg::t_weight'($urandom);
        endcase
    endfunction

    // Result checker and command acceptance, both at the rising edge
    always @(posedge i_clk) begin : monitor
        gsdfs_pkg::t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: kind %0d from %0d to %0d",
                       o_result.kind, o_result.from_node, o_result.to_node);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_result.kind);
                    fail_count++;
                end
                if (o_result.from_node !== want.from_node) begin
                    $error("from_node: expected %0d, got %0d",
                           want.from_node, o_result.from_node);
                    fail_count++;
                end
                if (o_result.to_node !== want.to_node) begin
                    $error("to_node: expected %0d, got %0d",
                           want.to_node, o_result.to_node);
                    fail_count++;
                end
                if (o_result.weight_out !== want.weight_out) begin
                    $error("weight_out: expected %0d, got %0d",
                           want.weight_out, o_result.weight_out);
                    fail_count++;
                end
            end
        end
        accepted = i_rst_n && start && !busy;
        if (accepted)
            predict_item(i_item);
    end

    // Command driver: presents the next queued command at the falling edge
    always @(negedge i_clk) begin : driver
        logic go;
        go = ($urandom_range(0, 99) >= 7) ||
             (items_sent >= QUIET_FIRST && items_sent < QUIET_LAST);
        if (i_rst_n && (!start || accepted)) begin
            if (go && cmd_queue.size() != 0 &&
                !(cmd_queue[0].hold_off && expected_results.size() != 0)) begin
                i_item <= cmd_queue[0].item;
                start <= 1'b1;
                void'(cmd_queue.pop_front());
                items_sent++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("** graph_store_dfs_walker_top: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int lo, hi, steps;
        gsdfs_pkg::t_node a, b, last_a, last_b;

        for (int i = 0; i < MAT_DEPTH; i++)
            mat_w[i] = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            head_of[i] = NO_ENTRY;
            seen[i] = 1'b0;
        end
        used_entries = 0;
        walk_depth = 0;
        visit_due = 1'b0;

        // Directed: done before any walk, empty cells, extreme weights, self loop
        queue_cmd(gsdfs_pkg::FUNC_STEP, 6'd0, 6'd0, '0);
        queue_cmd(gsdfs_pkg::FUNC_QUERY, 6'd0, 6'd0, '0);
        queue_cmd(gsdfs_pkg::FUNC_ADD, 6'd0, 6'd63, 32'h7FFF_FFFF);
        queue_cmd(gsdfs_pkg::FUNC_ADD, 6'd63, 6'd63, 32'h8000_0000);
        queue_cmd(gsdfs_pkg::FUNC_ADD, 6'd0, 6'd1, '0);
        queue_cmd(gsdfs_pkg::FUNC_QUERY, 6'd63, 6'd0, '1);
        queue_cmd(gsdfs_pkg::FUNC_QUERY, 6'd63, 6'd63, '0);
        // Full walk from node 0, through the self loop, to done and past it
        queue_cmd(gsdfs_pkg::FUNC_START, 6'd0, 6'd63, 32'hFFFF_FFFF);
        repeat (14)
            queue_cmd(gsdfs_pkg::FUNC_STEP, 6'd63, 6'd63, '1);
        // Restart in the middle of a walk, after a full drain
        queue_cmd(gsdfs_pkg::FUNC_START, 6'd63, 6'd0, '0);
        queue_cmd(gsdfs_pkg::FUNC_STEP, 6'd0, 6'd0, '0);
        queue_cmd(gsdfs_pkg::FUNC_START, 6'd1, 6'd0, '0, 1'b1);

        // Random episodes: build a local subgraph, query it, walk it
        last_a = '0;
        last_b = '0;
        while (items_queued < ITEM_TARGET) begin
            lo = $urandom_range(0, MAX_NODES - 1);
            hi = (lo + $urandom_range(3, 12) > MAX_NODES - 1) ?
                 MAX_NODES - 1 : lo + $urandom_range(3, 12);
            repeat ($urandom_range(0, 12)) begin
                a = pick_node(lo, hi);
                b = pick_node(lo, hi);
                queue_cmd(gsdfs_pkg::FUNC_ADD, a, b, pick_weight());
                last_a = a;
                last_b = b;
            end
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 1) == 0)
                    queue_cmd(gsdfs_pkg::FUNC_QUERY, last_b, last_a, pick_weight());
                else
                    queue_cmd(gsdfs_pkg::FUNC_QUERY, pick_node(lo, hi), pick_node(lo, hi),
                              pick_weight());
            end
            queue_cmd(gsdfs_pkg::FUNC_START, pick_node(lo, hi), pick_node(0, MAX_NODES - 1),
                      pick_weight(), $urandom_range(0, 9) == 0);
            steps = ($urandom_range(0, 29) == 0) ? 300 : $urandom_range(1, 40);
            repeat (steps)
                queue_cmd(gsdfs_pkg::FUNC_STEP, pick_node(0, MAX_NODES - 1),
                          pick_node(0, MAX_NODES - 1), pick_weight());
            // Occasional noise: arbitrary commands in arbitrary order
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 5))
                    queue_cmd(gsdfs_pkg::t_func'($urandom_range(0, 3)),
                              pick_node(0, MAX_NODES - 1), pick_node(0, MAX_NODES - 1),
                              pick_weight());
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands: %0d edges added, %0d adds refused on a full store,",
                 items_sent, n_added, n_full);
        $display("%0d queries, %0d walks, %0d visits, %0d edges examined, %0d pops, %0d done",
                 n_queries, n_starts, n_visits, n_examined, n_pops, n_done);
        if (fail_count == 0)
            $display("** graph_store_dfs_walker_top: PASSED **");
        else
            $display("** graph_store_dfs_walker_top: FAILED **");
        $finish;
    end

endmodule

// File: graph_store_dfs_walker_top.f
rtl/gsdfs_pkg.sv
rtl/graph_store_dfs_walker_top.sv
sim/graph_store_dfs_walker_top_tb.sv
